@@ sv/hsl2rgb_pkg.sv @@
// hsl2rgb_pkg: shared constants, the channel byte type and the byte saturation helper
// for the hsl to rgb converter pipeline. No dependencies.
`default_nettype none

package hsl2rgb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_STAGES    = 6;
  localparam int BYTE_W        = 8;
  localparam int WIDE_BYTE_W   = BYTE_W + 2;

  typedef logic [BYTE_W-1:0] pix_byte_t;

  localparam pix_byte_t BYTE_MAX = '1;

  // clip a rounded channel value to a byte
  function automatic pix_byte_t sat_byte(input logic [WIDE_BYTE_W-1:0] v);
    pix_byte_t res;
    if (v > WIDE_BYTE_W'(BYTE_MAX)) begin
      res = BYTE_MAX;
    end else begin
      res = v[BYTE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/hsl2rgb_front.sv @@
// hsl2rgb_front: first two pipeline stages - input clamping, l*s product, rounded p/q
// levels, wrapped hue positions for the three channels and the gray byte. Uses hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_front import hsl2rgb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [1:0]           stage_en,
  input  logic [FRAC_BITS:0]   hue,
  input  logic [FRAC_BITS:0]   saturation,
  input  logic [FRAC_BITS:0]   lightness,
  output logic                 gray,
  output pix_byte_t            gray_byte,
  output logic [FRAC_BITS:0]   p_lvl,
  output logic [FRAC_BITS:0]   q_lvl,
  output logic [FRAC_BITS:0]   d_lvl,
  output logic [FRAC_BITS+1:0] t_red,
  output logic [FRAC_BITS+1:0] t_green,
  output logic [FRAC_BITS+1:0] t_blue
);

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = 2 * FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 2;
  localparam int XW = TW + 1;
  localparam int GW = W + 9;

  localparam logic [W-1:0]  ONE       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0]  HALF      = ONE >> 1;
  localparam logic [XW-1:0] ONE_X     = XW'(ONE);
  localparam logic [XW-1:0] THREE_ONE = XW'(3) << FRAC_BITS;

  // stage 1
  logic [W-1:0]  h_c, s_c, l_c;
  logic [PW-1:0] ls_nxt;
  logic [TW-1:0] h3_nxt;
  logic [GW-1:0] gx;

  logic [W-1:0]           l_r, s_r;
  logic [PW-1:0]          ls_r;
  logic [TW-1:0]          h3_r;
  logic                   gray1_r, lo_r;
  logic [WIDE_BYTE_W-1:0] gw_r;

  assign h_c    = (hue > ONE) ? ONE : hue;
  assign s_c    = (saturation > ONE) ? ONE : saturation;
  assign l_c    = (lightness > ONE) ? ONE : lightness;
  assign ls_nxt = PW'(l_c) * PW'(s_c);
  assign h3_nxt = (TW'(h_c) << 1) + TW'(h_c);
  // l*255 + one half, as l*256 - l
  assign gx     = {1'b0, l_c, 8'b0} - GW'(l_c) + GW'(HALF);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      l_r     <= l_c;
      s_r     <= s_c;
      ls_r    <= ls_nxt;
      h3_r    <= h3_nxt;
      gray1_r <= (s_c == '0);
      lo_r    <= (l_c < HALF);
      gw_r    <= gx[GW-1:FRAC_BITS];
    end
  end

  // stage 2
  logic [PW-1:0] l_one_rnd, s_one, q2r, p2r;
  logic [W-1:0]  q_nxt, p_nxt;
  logic [XW-1:0] h3e, tr, tb;
  logic [TW-1:0] t_red_nxt, t_blue_nxt;

  logic [W-1:0]  p_r, q_r, d_r;
  logic [TW-1:0] t_red_r, t_green_r, t_blue_r;
  logic          gray_r;
  pix_byte_t     gray_byte_r;

  // l*one with the rounding half folded into the zero low bits
  assign l_one_rnd = PW'({l_r, 1'b1, {(FRAC_BITS-1){1'b0}}});
  assign s_one     = PW'({s_r, {FRAC_BITS{1'b0}}});
  assign q2r       = lo_r ? (l_one_rnd + ls_r) : (l_one_rnd + s_one - ls_r);
  assign p2r       = lo_r ? (l_one_rnd - ls_r) : (l_one_rnd - s_one + ls_r);
  assign q_nxt     = q2r[2*FRAC_BITS:FRAC_BITS];
  assign p_nxt     = p2r[2*FRAC_BITS:FRAC_BITS];

  assign h3e = XW'(h3_r);
  assign tr  = h3e + ONE_X;
  assign tb  = h3e - ONE_X;
  // wrap only strictly above three; a negative blue position wraps up
  assign t_red_nxt  = (tr > THREE_ONE) ? TW'(tr - THREE_ONE) : TW'(tr);
  assign t_blue_nxt = tb[XW-1] ? TW'(tb + THREE_ONE) : TW'(tb);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      p_r         <= p_nxt;
      q_r         <= q_nxt;
      d_r         <= q_nxt - p_nxt;
      t_red_r     <= t_red_nxt;
      t_green_r   <= h3_r;
      t_blue_r    <= t_blue_nxt;
      gray_r      <= gray1_r;
      gray_byte_r <= sat_byte(gw_r);
    end
  end

  assign p_lvl     = p_r;
  assign q_lvl     = q_r;
  assign d_lvl     = d_r;
  assign t_red     = t_red_r;
  assign t_green   = t_green_r;
  assign t_blue    = t_blue_r;
  assign gray      = gray_r;
  assign gray_byte = gray_byte_r;

endmodule

`default_nettype wire

@@ sv/hsl2rgb_chan.sv @@
// hsl2rgb_chan: one color channel, pipeline stages three to five - hue segment select,
// slope multiply, level sum, then the combinational scale to a byte. Uses hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_chan import hsl2rgb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [2:0]           stage_en,
  input  logic [FRAC_BITS:0]   p_lvl,
  input  logic [FRAC_BITS:0]   q_lvl,
  input  logic [FRAC_BITS:0]   d_lvl,
  input  logic [FRAC_BITS+1:0] t_pos,
  output pix_byte_t            ch_byte
);

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = 2 * FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 2;
  localparam int BW = PW + 8;

  localparam logic [TW-1:0] T_HALF     = TW'(1) << (FRAC_BITS - 1);
  localparam logic [TW-1:0] T_ONE_HALF = TW'(3) << (FRAC_BITS - 1);
  localparam logic [TW-1:0] T_TWO      = TW'(2) << FRAC_BITS;
  localparam logic [BW-1:0] RND_HALF   = BW'(1) << (2 * FRAC_BITS - 1);

  // stage 3: segment of the hue curve
  logic          rise, flat, fall;
  logic [TW:0]   t2, fall2;
  logic [TW-1:0] fall_d;
  logic [W-1:0]  m_nxt;

  logic [W-1:0] m_r, p3_r, q3_r, d3_r;
  logic         qsel_r;

  assign rise   = (t_pos < T_HALF);
  assign flat   = !rise && (t_pos < T_ONE_HALF);
  assign fall   = !rise && !flat && (t_pos < T_TWO);
  assign t2     = {t_pos, 1'b0};
  assign fall_d = T_TWO - t_pos;
  assign fall2  = {fall_d, 1'b0};

  always_comb begin
    m_nxt = '0;
    if (rise) begin
      m_nxt = t2[W-1:0];
    end else if (fall) begin
      m_nxt = fall2[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      m_r    <= m_nxt;
      qsel_r <= flat;
      p3_r   <= p_lvl;
      q3_r   <= q_lvl;
      d3_r   <= d_lvl;
    end
  end

  // stage 4: slope times position
  logic [PW-1:0] prod_r;
  logic [W-1:0]  base_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      prod_r <= PW'(d3_r) * PW'(m_r);
      base_r <= qsel_r ? q3_r : p3_r;
    end
  end

  // stage 5: level with double fraction width
  logic [PW-1:0] c2_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      c2_r <= PW'({base_r, {FRAC_BITS{1'b0}}}) + prod_r;
    end
  end

  // c2*255 as c2*256 - c2, rounded half up
  logic [BW-1:0] scaled;

  assign scaled  = {c2_r, 8'b0} - BW'(c2_r) + RND_HALF;
  assign ch_byte = sat_byte(scaled[BW-1:2*FRAC_BITS]);

endmodule

`default_nettype wire

@@ sv/hsl_to_rgb_converter.sv @@
// hsl_to_rgb_converter: takes one hue/saturation/lightness transfer per cycle unless stalled
// and returns red, green and blue bytes through a six-stage pipeline with a valid bit
// per stage; each stage loads when it is empty or the stage after it moves on, so a stall
// at the output fills bubbles first and loses nothing. Throughput is one item per clock
// unless stalled; the per-channel slope multiplier in stage four and the l*s product
// in stage one set the clock period. Inputs above 1.0 are clipped to 1.0, and zero
// saturation gives gray. Depends on hsl2rgb_pkg, hsl2rgb_front and hsl2rgb_chan.
`default_nettype none

module hsl_to_rgb_converter import hsl2rgb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FRAC_BITS:0] in_hue,
  input  logic [FRAC_BITS:0] in_saturation,
  input  logic [FRAC_BITS:0] in_lightness,
  output logic               out_valid,
  input  logic               out_ready,
  output pix_byte_t          out_red,
  output pix_byte_t          out_green,
  output pix_byte_t          out_blue
);

  localparam int LAST = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] valid_r, valid_nxt, stage_en;

  always_comb begin
    stage_en[LAST] = !valid_r[LAST] || out_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      stage_en[i] = !valid_r[i] || stage_en[i+1];
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (stage_en[i]) begin
        valid_nxt[i] = (i == 0) ? in_valid : valid_r[(i == 0) ? 0 : i - 1];
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = valid_r[LAST];

  logic                 gray;
  pix_byte_t            gray_byte;
  logic [FRAC_BITS:0]   p_lvl, q_lvl, d_lvl;
  logic [FRAC_BITS+1:0] t_red, t_green, t_blue;
  pix_byte_t            red_byte, green_byte, blue_byte;

  hsl2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .stage_en   (stage_en[1:0]),
    .hue        (in_hue),
    .saturation (in_saturation),
    .lightness  (in_lightness),
    .gray       (gray),
    .gray_byte  (gray_byte),
    .p_lvl      (p_lvl),
    .q_lvl      (q_lvl),
    .d_lvl      (d_lvl),
    .t_red      (t_red),
    .t_green    (t_green),
    .t_blue     (t_blue)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_red (
    .clk      (clk),
    .stage_en (stage_en[4:2]),
    .p_lvl    (p_lvl),
    .q_lvl    (q_lvl),
    .d_lvl    (d_lvl),
    .t_pos    (t_red),
    .ch_byte  (red_byte)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_green (
    .clk      (clk),
    .stage_en (stage_en[4:2]),
    .p_lvl    (p_lvl),
    .q_lvl    (q_lvl),
    .d_lvl    (d_lvl),
    .t_pos    (t_green),
    .ch_byte  (green_byte)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_blue (
    .clk      (clk),
    .stage_en (stage_en[4:2]),
    .p_lvl    (p_lvl),
    .q_lvl    (q_lvl),
    .d_lvl    (d_lvl),
    .t_pos    (t_blue),
    .ch_byte  (blue_byte)
  );

  // gray flag and byte ride along with the channel stages
  logic      gray_d_r [3];
  pix_byte_t gbyte_d_r [3];

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      gray_d_r[0]  <= gray;
      gbyte_d_r[0] <= gray_byte;
    end
    if (stage_en[3]) begin
      gray_d_r[1]  <= gray_d_r[0];
      gbyte_d_r[1] <= gbyte_d_r[0];
    end
    if (stage_en[4]) begin
      gray_d_r[2]  <= gray_d_r[1];
      gbyte_d_r[2] <= gbyte_d_r[1];
    end
  end

  // output register
  pix_byte_t red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (stage_en[LAST]) begin
      red_r   <= gray_d_r[2] ? gbyte_d_r[2] : red_byte;
      green_r <= gray_d_r[2] ? gbyte_d_r[2] : green_byte;
      blue_r  <= gray_d_r[2] ? gbyte_d_r[2] : blue_byte;
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // a pipeline with an empty slot or a draining output must take a transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    (!(&valid_r) || out_ready) |-> in_ready)
    else $error("input stalled while the pipeline has room");

  // occupancy grows by one on an input transfer without an output transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(out_valid && out_ready)) |=>
      ($countones(valid_r) == $past($countones(valid_r)) + 1))
    else $error("item lost on entry");

  // occupancy shrinks by one on an output transfer without an input transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !(in_valid && in_ready)) |=>
      ($countones(valid_r) + 1 == $past($countones(valid_r))))
    else $error("item repeated or lost on exit");

endmodule

`default_nettype wire

@@ bench/hsl_rgb_checker.sv @@
// hsl_rgb_checker: watches the input and result channels of hsl_to_rgb_converter, predicts
// each pixel's red/green/blue bytes and compares them in order of arrival.
// Depends on hsl2rgb_pkg for the byte type and the fraction width.
`timescale 1ns / 100ps

module hsl_rgb_checker import hsl2rgb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [FRAC_BITS_DEF:0] in_hue,
  input  logic [FRAC_BITS_DEF:0] in_saturation,
  input  logic [FRAC_BITS_DEF:0] in_lightness,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  pix_byte_t              out_red,
  input  pix_byte_t              out_green,
  input  pix_byte_t              out_blue,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int     FB  = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  typedef struct packed {
    pix_byte_t red;
    pix_byte_t green;
    pix_byte_t blue;
  } rgb_t;

  rgb_t expected_rgb[$];
  int   err_total = 0;

  function automatic longint clip_unit(input logic [FB:0] v);
    longint x;
    x = longint'(v);
    return (x > ONE) ? ONE : x;
  endfunction

  // t is the hue times three, shifted by the channel offset
  function automatic pix_byte_t hue_channel(input longint p, input longint q, input longint t);
    longint c2;
    longint b;
    if (t < 0) t = t + 3 * ONE;
    if (t > 3 * ONE) t = t - 3 * ONE;
    if (2 * t < ONE) begin
      c2 = p * ONE + (q - p) * 2 * t;
    end else if (2 * t < 3 * ONE) begin
      c2 = q * ONE;
    end else if (t < 2 * ONE) begin
      c2 = p * ONE + (q - p) * 2 * (2 * ONE - t);
    end else begin
      c2 = p * ONE;
    end
    if (c2 < 0) c2 = 0;
    b = (c2 * 255 + (longint'(1) << (2 * FB - 1))) >>> (2 * FB);
    return (b > 255) ? BYTE_MAX : pix_byte_t'(b);
  endfunction

  function automatic rgb_t predict_rgb(input logic [FB:0] h_in, input logic [FB:0] s_in,
                                       input logic [FB:0] l_in);
    longint h, s, l, g, q2, p2, q, p;
    rgb_t   px;
    h = clip_unit(h_in);
    s = clip_unit(s_in);
    l = clip_unit(l_in);
    if (s == 0) begin
      g = (l * 255 + ONE / 2) >>> FB;
      px.red   = (g > 255) ? BYTE_MAX : pix_byte_t'(g);
      px.green = px.red;
      px.blue  = px.red;
    end else begin
      if (2 * l < ONE) begin
        q2 = l * (ONE + s);
      end else begin
        q2 = l * ONE + s * ONE - l * s;
      end
      p2 = 2 * l * ONE - q2;
      if (p2 < 0) p2 = 0;
      q = (q2 + ONE / 2) >>> FB;
      p = (p2 + ONE / 2) >>> FB;
      px.red   = hue_channel(p, q, 3 * h + ONE);
      px.green = hue_channel(p, q, 3 * h);
      px.blue  = hue_channel(p, q, 3 * h - ONE);
    end
    return px;
  endfunction

  task automatic check_byte(input string name, input pix_byte_t want, input pix_byte_t got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin : monitor
    rgb_t want_px;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rgb.size() == 0) begin
          $error("result transfer with no pixel outstanding: r=%0d g=%0d b=%0d",
                 out_red, out_green, out_blue);
          err_total++;
        end else begin
          want_px = expected_rgb.pop_front();
          check_byte("red", want_px.red, out_red);
          check_byte("green", want_px.green, out_green);
          check_byte("blue", want_px.blue, out_blue);
        end
      end
      if (in_valid && in_ready) begin
        expected_rgb.push_back(predict_rgb(in_hue, in_saturation, in_lightness));
      end
    end
    mismatches  <= err_total;
    outstanding <= expected_rgb.size();
  end

endmodule

@@ bench/hsl_to_rgb_converter_tb.sv @@
// hsl_to_rgb_converter_tb: drives hue/saturation/lightness pixels into the converter with
// random gaps and output stalls, and gives the verdict from hsl_rgb_checker.
// Depends on hsl2rgb_pkg, hsl_to_rgb_converter and hsl_rgb_checker.
`timescale 1ns / 100ps

module hsl_to_rgb_converter_tb import hsl2rgb_pkg::*;;

  localparam int             FB        = FRAC_BITS_DEF;

  typedef logic [FB:0] frac_t;

  localparam frac_t          ONE       = {1'b1, {FB{1'b0}}};
  localparam frac_t          HALF      = ONE >> 1;
  localparam frac_t          FULL      = '1;
  localparam int             NUM_RAND  = 1350;

  logic          clk           = 1'b0;
  logic          rst_n         = 1'b0;
  logic          in_valid      = 1'b0;
  logic          in_ready;
  logic [FB:0]   in_hue        = '0;
  logic [FB:0]   in_saturation = '0;
  logic [FB:0]   in_lightness  = '0;
  logic          out_valid;
  logic          out_ready     = 1'b0;
  pix_byte_t     out_red;
  pix_byte_t     out_green;
  pix_byte_t     out_blue;

  int            mismatches;
  int            outstanding;
  bit            tx_burst      = 1'b0;
  bit            rx_burst      = 1'b0;
  int unsigned   rx_hold       = 0;
  int            sent_total    = 0;
  int            sent_gray     = 0;
  int            sent_clipped  = 0;

  always #10 clk = ~clk;

  hsl_to_rgb_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_hue(in_hue), .in_saturation(in_saturation), .in_lightness(in_lightness),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  hsl_rgb_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_hue(in_hue), .in_saturation(in_saturation), .in_lightness(in_lightness),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // receiver: after each result transfer, hold ready low for a random stall, which may be empty
  always @(posedge clk) begin : rx_stall
    int unsigned stall;
    stall = rx_burst ? 0 : $urandom_range(0, 15);
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else if (out_ready && out_valid) begin
      rx_hold   <= stall;
      out_ready <= (stall == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // entered and left at a rising edge; returns at the edge that takes the transfer
  task automatic send_pixel(input logic [FB:0] h, input logic [FB:0] s, input logic [FB:0] l);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_lightness  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
    if (s == 0) sent_gray++;
    if (h > ONE || s > ONE || l > ONE) sent_clipped++;
  endtask

  // mostly in range, with corners and some values above one
  function automatic logic [FB:0] rand_frac();
    logic [FB:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = ONE;
      2:       v = frac_t'($urandom_range(0, FULL));
      3:       v = ONE - frac_t'($urandom_range(0, 3));
      default: v = frac_t'($urandom_range(0, ONE));
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // gray path
    send_pixel(0, 0, 0);
    send_pixel(0, 0, ONE);
    send_pixel(0, 0, HALF);
    send_pixel(12345, 0, FULL);
    // primaries and sector boundaries of the hue
    send_pixel(0, ONE, HALF);
    send_pixel(21845, ONE, HALF);
    send_pixel(43691, ONE, HALF);
    send_pixel(10922, ONE, HALF);
    send_pixel(10923, ONE, HALF);
    send_pixel(32768, ONE, HALF);
    send_pixel(43690, ONE, HALF);
    send_pixel(54613, ONE, HALF);
    // hue of exactly one wraps like zero, above one is clipped
    send_pixel(ONE, ONE, HALF);
    send_pixel(FULL, ONE, HALF);
    // lightness around one half picks the other q formula
    send_pixel(0, 1, HALF - 1'b1);
    send_pixel(0, 1, HALF);
    send_pixel(0, ONE, ONE);
    send_pixel(0, ONE, 0);
    send_pixel(21845, FULL, FULL);
    send_pixel(FULL, FULL, 0);
    send_pixel(43690, 40000, 20000);
    send_pixel(5000, ONE - 1'b1, ONE - 1'b1);
    send_pixel(ONE - 1'b1, 30000, 50000);

    for (int i = 0; i < NUM_RAND; i++) begin
      if (i % 150 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst <= ($urandom_range(0, 3) == 0);
      end
      if (i == NUM_RAND / 2) wait_drained();
      send_pixel(rand_frac(), rand_frac(), rand_frac());
    end

    wait_drained();
    repeat (NUM_STAGES * 4) @(posedge clk);

    $display("sent %0d pixels (%0d gray, %0d with inputs above one)",
             sent_total, sent_gray, sent_clipped);
    $display("hue sectors, rounding edges, random gaps and output stalls exercised");
    if (mismatches == 0 && outstanding == 0) begin
      $display("hsl_to_rgb_converter verification clean");
    end else begin
      $display("hsl_to_rgb_converter verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("hsl_to_rgb_converter verification failed");
    $finish;
  end

endmodule
